// ===== src/fpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point ALU
// Opcodes, request/result structs and default fraction width.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FracBitsDef = 8;
  localparam int WordW       = 32;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MIN  = 4'd4,
    OP_MAX  = 4'd5,
    OP_INC  = 4'd6,
    OP_DEC  = 4'd7,
    OP_I2F  = 4'd8,
    OP_F2I  = 4'd9
  } op_t;

  typedef struct packed {
    logic        [3:0]  kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               less_than;
    logic               equal_to;
    logic               greater_than;
    logic               error_flag;
  } fpa_out_t;

  // sideband carried along the pipeline beside the arithmetic units
  typedef struct packed {
    logic        [3:0]  kind;
    logic        [31:0] simple_res;
    logic               less_than;
    logic               equal_to;
    logic               greater_than;
    logic               neg;
    logic               div_zero;
  } fpa_side_t;

endpackage

// ===== src/fpa_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_mul: pipelined rounded magnitude multiplier
// Multiplies two 33-bit magnitudes in two partial products over three
// stages and rounds the product by the fraction width, half away from zero.
// It registers the operands, the partial products, the sum and the rounded result;
// the top level delays the output to line up with the divider.
// ----------------------------------------------------------------------------
module fpa_mul #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic [32:0] mag_a,
  input  logic [32:0] mag_b,
  output logic [64:0] mag_q
);
  import fpa_pkg::*;

  logic [32:0] a_r, b_r;
  logic [49:0] p_lo_r, p_hi_r;
  logic [65:0] prod_r;
  logic [64:0] mag_r;

  // register operands, form two partial products, sum, then round
  always_ff @(posedge clk) begin
    a_r    <= mag_a;
    b_r    <= mag_b;
    p_lo_r <= {17'd0, a_r} * {33'd0, b_r[16:0]};
    p_hi_r <= {17'd0, a_r} * {34'd0, b_r[32:17]};
    prod_r <= {16'd0, p_lo_r} + {p_hi_r[48:0], 17'd0};
    mag_r  <= 65'((prod_r + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
  end

  assign mag_q = mag_r;

endmodule

// ===== src/fpa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div: pipelined restoring divider for rounded fixed-point quotients
// Computes floor((2*num + den) / (2*den)) one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpa_div #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic [32:0] mag_a,
  input  logic [32:0] mag_b,
  output logic [64:0] mag_q
);
  import fpa_pkg::*;

  localparam int NW    = 33 + FRAC_BITS + 1;  // width of 2*num + den
  localparam int QBITS = NW;

  logic [NW-1:0] num_r [QBITS+1];
  logic [NW:0]   rem_r [QBITS+1];
  logic [NW-1:0] quo_r [QBITS+1];
  logic [NW-1:0] den_r [QBITS+1];

  // load stage: numerator 2*num+den, divisor 2*den
  always_ff @(posedge clk) begin
    num_r[0] <= NW'({mag_a, 1'b0, FRAC_BITS'(0)}) + NW'(mag_b);
    den_r[0] <= NW'({mag_b, 1'b0});
    rem_r[0] <= '0;
    quo_r[0] <= '0;
  end

  // one quotient bit per stage
  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    logic [NW:0] sh;
    logic [NW:0] diff;
    assign sh   = {rem_r[s][NW-1:0], num_r[s][NW-1-s]};
    assign diff = sh - {1'b0, den_r[s]};
    always_ff @(posedge clk) begin
      num_r[s+1] <= num_r[s];
      den_r[s+1] <= den_r[s];
      if (!diff[NW]) begin
        rem_r[s+1] <= diff;
        quo_r[s+1] <= {quo_r[s][NW-2:0], 1'b1};
      end else begin
        rem_r[s+1] <= sh;
        quo_r[s+1] <= {quo_r[s][NW-2:0], 1'b0};
      end
    end
  end

  assign mag_q = 65'(quo_r[QBITS]);

endmodule

// ===== src/fixed_point_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu: pipelined signed Q(32-F).F arithmetic unit
// Usage: drive in_req with kind and operands and pulse start; a request is
// taken on every edge with start high and busy low. busy is always low, so a
// new request may enter every cycle.
// Each result appears on out_res for one cycle with out_valid high, in
// request order. The latency is set by the divider, which resolves one
// quotient bit per stage; the multiplier and the simple operations are
// delayed to line up with it. Throughput is one request per cycle.
// The receiver cannot stall: results must be taken when shown.
// Reset clears the valid bits of the pipeline; no result appears until a
// request has travelled through it.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fpa_pkg::fpa_in_t  in_req,
  output logic              out_valid,
  output fpa_pkg::fpa_out_t out_res
);
  import fpa_pkg::*;

  localparam int LAT_DIV = 33 + FRAC_BITS + 1 + 1;

  logic [32:0] mag_a, mag_b;
  logic [64:0] mul_q, div_q, mul_d_r [LAT_DIV-4];
  fpa_side_t   side;
  fpa_side_t   side_r [LAT_DIV];
  logic        vld_r  [LAT_DIV];
  logic [31:0] res_nxt;
  logic        err_nxt;
  logic [64:0] mag_sel;
  fpa_out_t    out_r;
  logic        out_valid_r;

  assign busy = 1'b0;

  // magnitudes and sideband
  always_comb begin
    logic signed [31:0] a, b;
    a = in_req.operand_a;
    b = in_req.operand_b;
    mag_a = a[31] ? 33'(-{1'b1, a}) : {1'b0, a};
    mag_b = b[31] ? 33'(-{1'b1, b}) : {1'b0, b};
    side.kind         = in_req.kind;
    side.less_than    = a < b;
    side.equal_to     = a == b;
    side.greater_than = a > b;
    side.neg          = a[31] ^ b[31];
    side.div_zero     = b == 0;
    case (in_req.kind)
      OP_ADD:  side.simple_res = a + b;
      OP_SUB:  side.simple_res = a - b;
      OP_MIN:  side.simple_res = (a < b) ? a : b;
      OP_MAX:  side.simple_res = (a > b) ? a : b;
      OP_INC:  side.simple_res = a + 32'd1;
      OP_DEC:  side.simple_res = a - 32'd1;
      OP_I2F:  side.simple_res = a << FRAC_BITS;
      OP_F2I: begin
        side.simple_res = 32'(mag_a >> FRAC_BITS);
        if (a[31]) side.simple_res = -side.simple_res;
      end
      default: side.simple_res = '0;
    endcase
  end

  fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .mag_a(mag_a), .mag_b(mag_b), .mag_q(mul_q));

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .mag_a(mag_a), .mag_b(mag_b), .mag_q(div_q));

  // advance sideband, delayed multiplier result and valid bits alongside the divider
  always_ff @(posedge clk) begin
    side_r[0] <= side;
    for (int i = 1; i < LAT_DIV; i++) side_r[i] <= side_r[i-1];
    mul_d_r[0] <= mul_q;
    for (int i = 1; i < LAT_DIV - 4; i++) mul_d_r[i] <= mul_d_r[i-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT_DIV; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= start;
      for (int i = 1; i < LAT_DIV; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // pick and saturate the final result
  always_comb begin
    fpa_side_t s;
    s       = side_r[LAT_DIV-1];
    mag_sel = (s.kind == OP_MUL) ? mul_d_r[LAT_DIV-5] : div_q;
    err_nxt = 1'b0;
    res_nxt = s.simple_res;
    if (s.kind == OP_MUL || s.kind == OP_DIV) begin
      if (s.kind == OP_DIV && s.div_zero) begin
        res_nxt = '0;
        err_nxt = 1'b1;
      end else if (s.neg) begin
        if (mag_sel > 65'h80000000) begin
          res_nxt = 32'h80000000;
          err_nxt = 1'b1;
        end else begin
          res_nxt = 32'(-mag_sel);
        end
      end else if (mag_sel > 65'h7FFFFFFF) begin
        res_nxt = 32'h7FFFFFFF;
        err_nxt = 1'b1;
      end else begin
        res_nxt = 32'(mag_sel);
      end
    end
  end

  // hold the result for one cycle
  always_ff @(posedge clk) begin
    out_r.result_value <= res_nxt;
    out_r.less_than    <= side_r[LAT_DIV-1].less_than;
    out_r.equal_to     <= side_r[LAT_DIV-1].equal_to;
    out_r.greater_than <= side_r[LAT_DIV-1].greater_than;
    out_r.error_flag   <= err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[LAT_DIV-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule
